>>> src/pidr_pkg.sv
// Package for the process id allocator with recycling.
// Holds field widths, operation and status codes, datapath command codes
// and the command and status structs shared by the controller and datapath.
package pidr_pkg;

    // Id space and bitmap geometry.
    localparam int ID_W          = 10;
    localparam int PID_LIMIT     = 1024;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int ROW_W         = ID_W - BIT_W;
    localparam int ROWS          = PID_LIMIT / WORD_W;
    localparam int DEF_RECYCLE_DEPTH = 1024;

    // Operation kinds of a request.
    localparam logic [2:0] KIND_ALLOC  = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_REMOVE = 3'd2;
    localparam logic [2:0] KIND_FIND   = 3'd3;
    localparam logic [2:0] KIND_FIRST  = 3'd4;
    localparam logic [2:0] KIND_NEXT   = 3'd5;

    // Result status codes.
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_ABSENT = 2'd1;
    localparam logic [1:0] STS_DUP    = 2'd2;
    localparam logic [1:0] STS_FULL   = 2'd3;

    // Datapath command codes.
    localparam logic [4:0] CMD_NONE       = 5'd0;
    localparam logic [4:0] CMD_CLR        = 5'd1;
    localparam logic [4:0] CMD_LOAD       = 5'd2;
    localparam logic [4:0] CMD_ALLOC_NEXT = 5'd3;
    localparam logic [4:0] CMD_POP        = 5'd4;
    localparam logic [4:0] CMD_TAKE_POP   = 5'd5;
    localparam logic [4:0] CMD_RDROW      = 5'd6;
    localparam logic [4:0] CMD_MARK       = 5'd7;
    localparam logic [4:0] CMD_CLEAR_BIT  = 5'd8;
    localparam logic [4:0] CMD_SETUP_UP   = 5'd9;
    localparam logic [4:0] CMD_RDSCAN     = 5'd10;
    localparam logic [4:0] CMD_STEP_UP    = 5'd11;
    localparam logic [4:0] CMD_STEP_DN    = 5'd12;
    localparam logic [4:0] CMD_FOUND_UP   = 5'd13;
    localparam logic [4:0] CMD_FOUND_DN   = 5'd14;
    localparam logic [4:0] CMD_EMPTY      = 5'd15;
    localparam logic [4:0] CMD_SET_ST     = 5'd16;
    localparam logic [4:0] CMD_FIND_OK    = 5'd17;
    localparam logic [4:0] CMD_EMIT       = 5'd18;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] st;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       count_zero;
        logic       nonempty;
        logic       largest_max;
        logic       bit_set;
        logic       is_largest;
        logic       stack_full;
        logic       hit;
        logic       row_first;
        logic       row_last;
        logic       out_free;
    } stat_t;

endpackage

>>> src/pid_allocator_with_recycle.sv
// Process id allocator with recycling: presence bitmap plus recycle stack.
// Find, insert and remove of a non-largest id pass dispatch, check and done; a refused
// allocate goes dispatch to done; a new largest id adds a row read, a recycled id a pop
// and a row read. Done waits for a free output register. First, next and removal of the
// largest id scan one 32-bit row per read and evaluate step. One request in flight;
// the next is taken only in idle. After reset the bitmap rows clear one per cycle, in_stall high.
module pid_allocator_with_recycle #(
    parameter int RECYCLE_DEPTH = pidr_pkg::DEF_RECYCLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                kind,
    input  logic [pidr_pkg::ID_W-1:0] pid,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pidr_pkg::ID_W-1:0] result_pid,
    output logic [1:0]                status
);
    import pidr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencing of each request.
    pidr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    pidr_dp #(
        .RECYCLE_DEPTH (RECYCLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .pid        (pid),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_pid (result_pid),
        .status     (status)
    );

endmodule

>>> src/pidr_ctrl.sv
// Controller state machine of the process id allocator.
// Depends on pidr_pkg for command codes and the command and status structs.
module pidr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pidr_pkg::stat_t stat,
    output pidr_pkg::cmd_t  cmd
);
    import pidr_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_POPW = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_RDUP = 4'd6;
    localparam logic [3:0] S_EVUP = 4'd7;
    localparam logic [3:0] S_RDDN = 4'd8;
    localparam logic [3:0] S_EVDN = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // A new request is taken only while idle.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        cmd.st     = STS_ABSENT;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = CMD_CLR;
                if (stat.row_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.kind)
                    KIND_ALLOC:
                    begin
                        if (!stat.count_zero)
                        begin
                            cmd.op     = CMD_POP;
                            state_next = S_POPW;
                        end
                        else if (!stat.nonempty)
                        begin
                            cmd.op     = CMD_SET_ST;
                            state_next = S_DONE;
                        end
                        else if (stat.largest_max)
                        begin
                            cmd.op     = CMD_SET_ST;
                            cmd.st     = STS_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = CMD_ALLOC_NEXT;
                            state_next = S_RD;
                        end
                    end
                    KIND_INSERT, KIND_REMOVE, KIND_FIND, KIND_NEXT:
                    begin
                        cmd.op     = CMD_RDROW;
                        state_next = S_CHK;
                    end
                    KIND_FIRST:
                    begin
                        cmd.op     = CMD_RDSCAN;
                        state_next = S_EVUP;
                    end
                    default:
                    begin
                        cmd.op     = CMD_SET_ST;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POPW:
            begin
                cmd.op     = CMD_TAKE_POP;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.op     = CMD_RDROW;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_DONE;
                cmd.op     = CMD_SET_ST;
                case (stat.kind)
                    KIND_ALLOC, KIND_INSERT:
                    begin
                        if (stat.bit_set)
                            cmd.st = STS_DUP;
                        else
                            cmd.op = CMD_MARK;
                    end
                    KIND_FIND:
                    begin
                        if (stat.bit_set)
                            cmd.op = CMD_FIND_OK;
                    end
                    KIND_REMOVE:
                    begin
                        if (stat.bit_set && !stat.is_largest && stat.stack_full)
                            cmd.st = STS_FULL;
                        else if (stat.bit_set)
                        begin
                            cmd.op = CMD_CLEAR_BIT;
                            if (stat.is_largest)
                                state_next = S_EVDN;
                        end
                    end
                    KIND_NEXT:
                    begin
                        if (stat.bit_set)
                        begin
                            cmd.op     = CMD_SETUP_UP;
                            state_next = S_EVUP;
                        end
                    end
                    default:
                    begin
                        cmd.op = CMD_SET_ST;
                    end
                endcase
            end
            S_EVUP:
            begin
                if (stat.hit)
                begin
                    cmd.op     = CMD_FOUND_UP;
                    state_next = S_DONE;
                end
                else if (stat.row_last)
                begin
                    cmd.op     = CMD_SET_ST;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_STEP_UP;
                    state_next = S_RDUP;
                end
            end
            S_RDUP:
            begin
                cmd.op     = CMD_RDSCAN;
                state_next = S_EVUP;
            end
            S_EVDN:
            begin
                if (stat.hit)
                begin
                    cmd.op     = CMD_FOUND_DN;
                    state_next = S_DONE;
                end
                else if (stat.row_first)
                begin
                    cmd.op     = CMD_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_STEP_DN;
                    state_next = S_RDDN;
                end
            end
            S_RDDN:
            begin
                cmd.op     = CMD_RDSCAN;
                state_next = S_EVDN;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the bitmap clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    // The clearing pass only ever leads to idle.
    a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && state_next != S_CLR) |-> state_next == S_IDLE)
        else $error("clearing pass left to a state other than idle");
    // A result is emitted only when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_EMIT) |-> stat.out_free)
        else $error("result emitted while the output register was busy");
    // An accepted request always goes to dispatch.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_DISP)
        else $error("accepted request did not reach dispatch");
`endif

endmodule

>>> src/pidr_dp.sv
// Datapath of the process id allocator: presence bitmap memory, recycle
// stack memory, working registers and output register. Depends on pidr_pkg.
module pidr_dp #(
    parameter int RECYCLE_DEPTH = pidr_pkg::DEF_RECYCLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               kind,
    input  logic [pidr_pkg::ID_W-1:0] pid,
    input  pidr_pkg::cmd_t           cmd,
    output pidr_pkg::stat_t          stat,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [pidr_pkg::ID_W-1:0] result_pid,
    output logic [1:0]               status
);
    import pidr_pkg::*;

    localparam int SAW = (RECYCLE_DEPTH > 1) ? $clog2(RECYCLE_DEPTH) : 1;
    localparam int CW  = $clog2(RECYCLE_DEPTH + 1);

    logic [WORD_W-1:0] bm_mem [ROWS];
    logic [ID_W-1:0]   stk_mem [RECYCLE_DEPTH];

    logic [2:0]        kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [WORD_W-1:0] mask_reg;
    logic [WORD_W-1:0] bm_q_reg;
    logic [ID_W-1:0]   stk_q_reg;
    logic [CW-1:0]     count_reg;
    logic [ID_W-1:0]   largest_reg;
    logic              nonempty_reg;
    logic [ID_W-1:0]   res_reg;
    logic [1:0]        st_reg;
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_pid_reg;
    logic [1:0]        out_st_reg;

    logic [WORD_W-1:0] onehot;
    logic [WORD_W-1:0] hit_word;
    logic [CW-1:0]     count_dec;
    logic              stack_full;
    logic              is_largest;

    // Lowest set bit of a word.
    function automatic logic [BIT_W-1:0] lsb_pos(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
            if (w[i])
                p = BIT_W'(i);
        return p;
    endfunction

    // Highest set bit of a word.
    function automatic logic [BIT_W-1:0] msb_pos(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++)
            if (w[i])
                p = BIT_W'(i);
        return p;
    endfunction

    assign onehot     = WORD_W'(1) << id_reg[BIT_W-1:0];
    assign hit_word   = bm_q_reg & mask_reg;
    assign count_dec  = count_reg - CW'(1);
    assign stack_full = (count_reg == CW'(RECYCLE_DEPTH));
    assign is_largest = (id_reg == largest_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.kind        = kind_reg;
        stat.count_zero  = (count_reg == '0);
        stat.nonempty    = nonempty_reg;
        stat.largest_max = (largest_reg == {ID_W{1'b1}});
        stat.bit_set     = bm_q_reg[id_reg[BIT_W-1:0]];
        stat.is_largest  = is_largest;
        stat.stack_full  = stack_full;
        stat.hit         = (hit_word != '0);
        stat.row_first   = (row_reg == '0);
        stat.row_last    = (row_reg == ROW_W'(ROWS - 1));
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_CLR)
            bm_mem[row_reg] <= '0;
        else if (cmd.op == CMD_MARK)
            bm_mem[id_reg[ID_W-1:BIT_W]] <= bm_q_reg | onehot;
        else if (cmd.op == CMD_CLEAR_BIT)
            bm_mem[id_reg[ID_W-1:BIT_W]] <= bm_q_reg & ~onehot;

        if (cmd.op == CMD_RDROW)
            bm_q_reg <= bm_mem[id_reg[ID_W-1:BIT_W]];
        else if (cmd.op == CMD_RDSCAN)
            bm_q_reg <= bm_mem[row_reg];
    end

    // Recycle stack memory.
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_CLEAR_BIT && !is_largest)
            stk_mem[count_reg[SAW-1:0]] <= id_reg;
        if (cmd.op == CMD_POP)
            stk_q_reg <= stk_mem[count_dec[SAW-1:0]];
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                kind_reg <= kind;
                id_reg   <= pid;
                mask_reg <= '1;
            end
            CMD_ALLOC_NEXT: id_reg <= largest_reg + ID_W'(1);
            CMD_TAKE_POP:   id_reg <= stk_q_reg;
            CMD_MARK, CMD_FIND_OK:
            begin
                res_reg <= id_reg;
                st_reg  <= STS_OK;
            end
            CMD_CLEAR_BIT:
            begin
                res_reg  <= id_reg;
                st_reg   <= STS_OK;
                mask_reg <= onehot - WORD_W'(1);
            end
            CMD_SETUP_UP:  mask_reg <= ~(onehot | (onehot - WORD_W'(1)));
            CMD_STEP_UP, CMD_STEP_DN: mask_reg <= '1;
            CMD_FOUND_UP:
            begin
                res_reg <= {row_reg, lsb_pos(hit_word)};
                st_reg  <= STS_OK;
            end
            CMD_SET_ST:
            begin
                res_reg <= '0;
                st_reg  <= cmd.st;
            end
            default:
            begin
            end
        endcase
    end

    // Row pointer, stack count and largest-id tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            count_reg    <= '0;
            largest_reg  <= '0;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                CMD_CLR:     row_reg <= row_reg + ROW_W'(1);
                CMD_LOAD:    row_reg <= '0;
                CMD_RDROW:   row_reg <= id_reg[ID_W-1:BIT_W];
                CMD_STEP_UP: row_reg <= row_reg + ROW_W'(1);
                CMD_STEP_DN: row_reg <= row_reg - ROW_W'(1);
                CMD_POP:     count_reg <= count_dec;
                CMD_MARK:
                begin
                    if (!nonempty_reg || id_reg > largest_reg)
                        largest_reg <= id_reg;
                    nonempty_reg <= 1'b1;
                end
                CMD_CLEAR_BIT:
                begin
                    if (!is_largest)
                        count_reg <= count_reg + CW'(1);
                end
                CMD_FOUND_DN: largest_reg <= {row_reg, msb_pos(hit_word)};
                CMD_EMPTY:
                begin
                    largest_reg  <= '0;
                    nonempty_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register, freed when the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == CMD_EMIT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_EMIT)
        begin
            out_pid_reg <= res_reg;
            out_st_reg  <= st_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_pid = out_pid_reg;
    assign status     = out_st_reg;

`ifndef ASSERT_OFF
    // The recycle count never passes the stack depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RECYCLE_DEPTH))
        else $error("recycle count beyond stack depth");
    // An empty set always reports a largest id of zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty_reg |-> largest_reg == '0)
        else $error("largest id nonzero while set is empty");
    // Marking an id always leaves the set nonempty.
    a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_MARK) |=> nonempty_reg)
        else $error("set empty after marking an id");
`endif

endmodule

>>> verif/pid_allocator_with_recycle_tb.sv
// Self-checking testbench for the process id allocator with recycling.
// Drives randomized and directed requests, predicts each result from a local
// model of the id set and recycle stack. Depends on pidr_pkg and the block.
`timescale 1ns / 1ps

module pid_allocator_with_recycle_tb;
    import pidr_pkg::*;

    localparam int DEPTH = DEF_RECYCLE_DEPTH;

    // Operation kinds that the block does not use.
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] pid;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] pid;
        logic [1:0]      st;
    } rsp_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [2:0]      kind;
    logic [ID_W-1:0] pid;
    logic            out_valid;
    logic            out_stall;
    logic [ID_W-1:0] result_pid;
    logic [1:0]      status;

    // Predictor state.
    bit              used_map [PID_LIMIT];
    logic [ID_W-1:0] freed_ids [DEPTH];
    int              freed_cnt;
    int              top_id;
    bit              any_used;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   errors;
    int   hold_cycles;
    bit   long_hold;
    int   send_gap;
    int   recv_gap;

    pid_allocator_with_recycle u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .pid        (pid),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_pid (result_pid),
        .status     (status)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Mark an id used and track the largest one.
    function automatic void take_id(int id);
        used_map[id] = 1'b1;
        if (!any_used || id > top_id)
            top_id = id;
        any_used = 1'b1;
    endfunction

    // Free an id; when it was the largest, search down for the new largest.
    function automatic void drop_id(int id);
        used_map[id] = 1'b0;
        if (id == top_id)
        begin
            for (int k = id - 1; k >= 0; k--)
            begin
                if (used_map[k])
                begin
                    top_id = k;
                    return;
                end
            end
            top_id = 0;
            any_used = 1'b0;
        end
    endfunction

    function automatic int first_used_from(int from);
        for (int k = from; k < PID_LIMIT; k++)
            if (used_map[k])
                return k;
        return -1;
    endfunction

    // Compute the result of one request and update the predicted state.
    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int   id;
        o.pid = '0;
        o.st  = STS_ABSENT;
        case (r.kind)
            KIND_ALLOC:
            begin
                if (freed_cnt > 0)
                begin
                    freed_cnt--;
                    id = int'(freed_ids[freed_cnt]);
                    if (used_map[id])
                        o.st = STS_DUP;
                    else
                    begin
                        take_id(id);
                        o.pid = ID_W'(id);
                        o.st = STS_OK;
                    end
                end
                else if (!any_used)
                    o.st = STS_ABSENT;
                else if (top_id + 1 >= PID_LIMIT)
                    o.st = STS_FULL;
                else
                begin
                    take_id(top_id + 1);
                    o.pid = ID_W'(top_id);
                    o.st = STS_OK;
                end
            end
            KIND_INSERT:
            begin
                if (used_map[r.pid])
                    o.st = STS_DUP;
                else
                begin
                    take_id(r.pid);
                    o.pid = r.pid;
                    o.st = STS_OK;
                end
            end
            KIND_REMOVE:
            begin
                if (!used_map[r.pid])
                    o.st = STS_ABSENT;
                else if (r.pid != top_id && freed_cnt >= DEPTH)
                    o.st = STS_FULL;
                else
                begin
                    if (r.pid != top_id)
                    begin
                        freed_ids[freed_cnt] = r.pid;
                        freed_cnt++;
                    end
                    drop_id(r.pid);
                    o.pid = r.pid;
                    o.st = STS_OK;
                end
            end
            KIND_FIND:
            begin
                if (used_map[r.pid])
                begin
                    o.pid = r.pid;
                    o.st = STS_OK;
                end
            end
            KIND_FIRST:
            begin
                id = first_used_from(0);
                if (id >= 0)
                begin
                    o.pid = ID_W'(id);
                    o.st = STS_OK;
                end
            end
            KIND_NEXT:
            begin
                id = (used_map[r.pid] && r.pid < PID_LIMIT - 1) ?
                     first_used_from(r.pid + 1) : -1;
                if (id >= 0)
                begin
                    o.pid = ID_W'(id);
                    o.st = STS_OK;
                end
            end
            default: ;
        endcase
        if (o.st != STS_OK)
            o.pid = '0;
        return o;
    endfunction

    function automatic void add_req(logic [2:0] k, int p);
        req_t r;
        r.kind = k;
        r.pid  = ID_W'(p);
        pending_reqs.push_back(r);
    endfunction

    // Random request, biased toward the lowest and the highest ids.
    function automatic req_t random_req();
        req_t r;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            r.kind = KIND_ALLOC;
        else if (sel < 45)
            r.kind = KIND_INSERT;
        else if (sel < 70)
            r.kind = KIND_REMOVE;
        else if (sel < 80)
            r.kind = KIND_FIND;
        else if (sel < 86)
            r.kind = KIND_FIRST;
        else if (sel < 96)
            r.kind = KIND_NEXT;
        else
            r.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE7 : KIND_SPARE6;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            r.pid = ID_W'($urandom_range(0, 63));
        else if (sel < 8)
            r.pid = ID_W'($urandom_range(PID_LIMIT - 64, PID_LIMIT - 1));
        else
            r.pid = ID_W'($urandom);
        return r;
    endfunction

    // Driver: offers the next queued request after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= '0;
            pid      <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            expected_rsps.push_back(apply_request('{kind, pid}));
            in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_reqs.size() > 0)
            begin
                req_t r;
                r = pending_reqs.pop_front();
                kind     <= r.kind;
                pid      <= r.pid;
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor: checks each accepted result and draws the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b1;
            recv_gap    <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result pid %0d status %0d",
                             $time, result_pid, status);
                    errors++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (e.pid !== result_pid)
                    begin
                        $display("%0t: result_pid expected %0d actual %0d",
                                 $time, e.pid, result_pid);
                        errors++;
                    end
                    if (e.st !== status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.st, status);
                        errors++;
                    end
                end
            end
            if (long_hold)
            begin
                hold_cycles <= hold_cycles + 1;
                out_stall   <= (hold_cycles < 400);
            end
            else if (out_valid && !out_stall)
            begin
                recv_gap  <= $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Checked between edges so that the driver's updates have settled.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin
        errors    = 0;
        long_hold = 1'b0;
        freed_cnt = 0;
        top_id    = 0;
        any_used  = 1'b0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty set, extremes, duplicates, recycle, limit.
        add_req(KIND_ALLOC, 0);
        add_req(KIND_FIRST, 0);
        add_req(KIND_REMOVE, 5);
        add_req(KIND_NEXT, 0);
        add_req(KIND_INSERT, 0);
        add_req(KIND_INSERT, 0);
        add_req(KIND_ALLOC, 1023);
        add_req(KIND_ALLOC, 0);
        add_req(KIND_REMOVE, 1);
        add_req(KIND_INSERT, 1);
        add_req(KIND_ALLOC, 0);
        add_req(KIND_INSERT, 1023);
        add_req(KIND_ALLOC, 0);
        add_req(KIND_FIND, 1023);
        add_req(KIND_NEXT, 2);
        add_req(KIND_NEXT, 1023);
        add_req(KIND_REMOVE, 1023);
        add_req(KIND_FIND, 1023);
        add_req(KIND_INSERT, 1022);
        add_req(KIND_NEXT, 0);
        add_req(KIND_SPARE6, 1023);
        add_req(KIND_SPARE7, 0);
        add_req(KIND_REMOVE, 0);
        add_req(KIND_FIRST, 0);
        wait_drained();

        // Pause, then fill the pipe while the receiver holds off.
        repeat (80) @(posedge clk);
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++)
            pending_reqs.push_back(random_req());
        wait_drained();
        long_hold = 1'b0;

        // Random body.
        for (int i = 0; i < 400; i++)
            pending_reqs.push_back(random_req());
        wait_drained();
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("pid_allocator_with_recycle_tb: PASS");
        else
            $display("pid_allocator_with_recycle_tb: FAIL");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("pid_allocator_with_recycle_tb: FAIL");
        $finish;
    end

endmodule
